### rtl/med_pkg.sv
// ----------------------------------------------------------------------------
// med_pkg: shared definitions for the message envelope deframer
// Header layout, register indexes, error codes and the result record.
// ----------------------------------------------------------------------------
package med_pkg;

    localparam int HDR_BYTES = 24;
    localparam int HDR_BITS  = HDR_BYTES * 8;
    localparam int POS_W     = 26;   // header plus largest accepted payload
    localparam int LEN_W     = 25;

    localparam logic [31:0] FRAME_MAGIC = 32'h474E_4932;

    // byte offsets inside the header
    localparam int OFS_MAGIC    = 0;
    localparam int OFS_MAJOR    = 4;
    localparam int OFS_MINOR    = 6;
    localparam int OFS_DOMAIN   = 8;
    localparam int OFS_OP       = 10;
    localparam int OFS_KIND     = 12;
    localparam int OFS_RESERVED = 14;
    localparam int OFS_REQID    = 16;
    localparam int OFS_LENGTH   = 20;

    // register reset values
    localparam logic [15:0]      RST_EXP_MAJOR = 16'd2;
    localparam logic [15:0]      RST_MAX_MINOR = 16'd0;
    localparam logic [LEN_W-1:0] RST_MAX_PAY   = 25'd65536;
    localparam logic [15:0]      RST_KIND_EVT  = 16'd0;
    localparam logic [15:0]      RST_KIND_REQ  = 16'd1;
    localparam logic [15:0]      RST_KIND_RSP  = 16'd2;
    localparam logic [15:0]      RST_KIND_ERR  = 16'd3;

    typedef enum logic [2:0] {
        REG_EXP_MAJOR = 3'd0,
        REG_MAX_MINOR = 3'd1,
        REG_MAX_PAY   = 3'd2,
        REG_KIND_EVT  = 3'd3,
        REG_KIND_REQ  = 3'd4,
        REG_KIND_RSP  = 3'd5,
        REG_KIND_ERR  = 3'd6
    } reg_idx_t;

    typedef enum logic [2:0] {
        ERR_OK         = 3'd0,
        ERR_BAD_MAGIC  = 3'd1,
        ERR_TOO_LONG   = 3'd2,
        ERR_BAD_FIELDS = 3'd3,
        ERR_FAILED     = 3'd4
    } err_t;

    typedef struct packed {
        logic             payload_valid;
        logic [7:0]       payload_byte;
        logic             envelope_done;
        logic [15:0]      ver_major;
        logic [15:0]      ver_minor;
        logic [15:0]      domain;
        logic [15:0]      operation;
        logic [15:0]      kind;
        logic [31:0]      req_tag;
        logic [LEN_W-1:0] payload_length;
        err_t             error_code;
        logic [LEN_W-1:0] buffered_bytes;
    } res_t;

endpackage

### rtl/message_envelope_deframer.sv
// ----------------------------------------------------------------------------
// message_envelope_deframer
// Byte-serial deframer for big-endian envelopes with header checks.
// ----------------------------------------------------------------------------
// One byte is taken per clock and one result leaves per byte; a new byte is
// accepted in every cycle as long as the result register is empty or being
// drained, so throughput is one byte per clock, and each result is registered
// (input byte to result register). An envelope is a 24-byte header (magic,
// major, minor, domain, operation, kind, reserved, request id, length)
// followed by the payload. Magic, reserved and length are checked on the
// last header byte; the remaining field checks are latched then and applied
// on the envelope's last byte, where the header fields come out with
// envelope_done. Payload bytes pass through as they arrive, so a consumer
// must drop them if the envelope ends in an error. Any error is sticky until
// reset: every later request returns error_code 4 and nothing else.
// Registers sit on an APB-style port at 4*index; write only while idle.
// ----------------------------------------------------------------------------
module message_envelope_deframer
    import med_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,

    // byte stream in
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_data_byte,

    // results out
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_payload_valid,
    output logic [7:0]       m_payload_byte,
    output logic             m_envelope_done,
    output logic [15:0]      m_ver_major,
    output logic [15:0]      m_ver_minor,
    output logic [15:0]      m_domain,
    output logic [15:0]      m_operation,
    output logic [15:0]      m_kind,
    output logic [31:0]      m_req_tag,
    output logic [LEN_W-1:0] m_payload_length,
    output logic [2:0]       m_error_code,
    output logic [LEN_W-1:0] m_buffered_bytes,

    // configuration
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0]      exp_major_reg;
    logic [15:0]      max_minor_reg;
    logic [LEN_W-1:0] max_pay_reg;
    logic [15:0]      kind_evt_reg;
    logic [15:0]      kind_req_reg;
    logic [15:0]      kind_rsp_reg;
    logic [15:0]      kind_err_reg;

    logic     cfg_wr;
    reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_major_reg <= RST_EXP_MAJOR;
            max_minor_reg <= RST_MAX_MINOR;
            max_pay_reg   <= RST_MAX_PAY;
            kind_evt_reg  <= RST_KIND_EVT;
            kind_req_reg  <= RST_KIND_REQ;
            kind_rsp_reg  <= RST_KIND_RSP;
            kind_err_reg  <= RST_KIND_ERR;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_EXP_MAJOR: exp_major_reg <= pwdata[15:0];
                REG_MAX_MINOR: max_minor_reg <= pwdata[15:0];
                REG_MAX_PAY:   max_pay_reg   <= pwdata[LEN_W-1:0];
                REG_KIND_EVT:  kind_evt_reg  <= pwdata[15:0];
                REG_KIND_REQ:  kind_req_reg  <= pwdata[15:0];
                REG_KIND_RSP:  kind_rsp_reg  <= pwdata[15:0];
                REG_KIND_ERR:  kind_err_reg  <= pwdata[15:0];
                default: ;    // addresses past the register list are ignored
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_EXP_MAJOR: prdata = {16'd0, exp_major_reg};
            REG_MAX_MINOR: prdata = {16'd0, max_minor_reg};
            REG_MAX_PAY:   prdata = {7'd0, max_pay_reg};
            REG_KIND_EVT:  prdata = {16'd0, kind_evt_reg};
            REG_KIND_REQ:  prdata = {16'd0, kind_req_reg};
            REG_KIND_RSP:  prdata = {16'd0, kind_rsp_reg};
            REG_KIND_ERR:  prdata = {16'd0, kind_err_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Deframer state
    // ------------------------------------------------------------------
    logic [POS_W-1:0] position_reg, position_next;
    logic [LEN_W-1:0] cur_len_reg, cur_len_next;
    logic             fields_ok_reg, fields_ok_next;
    logic             failed_reg, failed_next;
    logic [7:0]       hdr_reg [HDR_BYTES];   // written before read, no reset

    logic             m_valid_reg;
    res_t             res_reg, res_next;

    logic             s_acc;
    logic             in_hdr;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_acc   = s_valid && s_ready;
    assign in_hdr  = position_reg < POS_W'(HDR_BYTES);

    // Header view with the current byte merged in, byte 0 at the top.
    logic [HDR_BITS-1:0] hdr_flat;

    always_comb begin
        for (int i = 0; i < HDR_BYTES; i++) begin
            hdr_flat[(HDR_BYTES-1-i)*8 +: 8] =
                (in_hdr && position_reg[4:0] == 5'(i)) ? s_data_byte : hdr_reg[5'(i)];
        end
    end

    logic [31:0] f_magic, f_reqid, f_length;
    logic [15:0] f_major, f_minor, f_domain, f_op, f_kind, f_resv;

    assign f_magic  = hdr_flat[(HDR_BYTES-OFS_MAGIC)*8-1    -: 32];
    assign f_major  = hdr_flat[(HDR_BYTES-OFS_MAJOR)*8-1    -: 16];
    assign f_minor  = hdr_flat[(HDR_BYTES-OFS_MINOR)*8-1    -: 16];
    assign f_domain = hdr_flat[(HDR_BYTES-OFS_DOMAIN)*8-1   -: 16];
    assign f_op     = hdr_flat[(HDR_BYTES-OFS_OP)*8-1       -: 16];
    assign f_kind   = hdr_flat[(HDR_BYTES-OFS_KIND)*8-1     -: 16];
    assign f_resv   = hdr_flat[(HDR_BYTES-OFS_RESERVED)*8-1 -: 16];
    assign f_reqid  = hdr_flat[(HDR_BYTES-OFS_REQID)*8-1    -: 32];
    assign f_length = hdr_flat[(HDR_BYTES-OFS_LENGTH)*8-1   -: 32];

    // Field checks; an event kind wins even if another code matches it.
    logic is_event, kind_known, chk_fields;

    assign is_event   = f_kind == kind_evt_reg;
    assign kind_known = is_event || f_kind == kind_req_reg ||
                        f_kind == kind_rsp_reg || f_kind == kind_err_reg;
    assign chk_fields = f_major == exp_major_reg && f_minor <= max_minor_reg &&
                        f_domain != 16'd0 && f_op != 16'd0 && kind_known &&
                        (is_event ? (f_reqid == 32'd0) : (f_reqid != 32'd0));

    logic [POS_W-1:0] pos_inc;
    logic             hdr_last;
    logic             ends;
    logic             fok_eff;

    assign pos_inc  = position_reg + POS_W'(1);
    assign hdr_last = position_reg == POS_W'(HDR_BYTES - 1);

    always_comb begin
        position_next  = position_reg;
        cur_len_next   = cur_len_reg;
        fields_ok_next = fields_ok_reg;
        failed_next    = failed_reg;
        res_next       = '0;
        res_next.error_code = ERR_OK;
        ends           = 1'b0;
        fok_eff        = fields_ok_reg;

        if (failed_reg) begin
            res_next.error_code = ERR_FAILED;
        end else if (in_hdr) begin
            position_next = pos_inc;
            if (hdr_last) begin
                if (f_magic != FRAME_MAGIC || f_resv != 16'd0) begin
                    res_next.error_code = ERR_BAD_MAGIC;
                    failed_next   = 1'b1;
                    position_next = '0;
                end else if (f_length > {7'd0, max_pay_reg}) begin
                    res_next.error_code = ERR_TOO_LONG;
                    failed_next   = 1'b1;
                    position_next = '0;
                end else begin
                    cur_len_next   = f_length[LEN_W-1:0];
                    fields_ok_next = chk_fields;
                    fok_eff        = chk_fields;
                    ends           = f_length == 32'd0;
                end
            end
        end else begin
            res_next.payload_valid = 1'b1;
            res_next.payload_byte  = s_data_byte;
            position_next = pos_inc;
            ends = (pos_inc - POS_W'(HDR_BYTES)) == {1'b0, cur_len_reg};
        end

        if (ends) begin
            position_next = '0;
            if (!fok_eff) begin
                res_next.error_code = ERR_BAD_FIELDS;
                failed_next = 1'b1;
            end else begin
                res_next.envelope_done  = 1'b1;
                res_next.ver_major      = f_major;
                res_next.ver_minor      = f_minor;
                res_next.domain         = f_domain;
                res_next.operation      = f_op;
                res_next.kind           = f_kind;
                res_next.req_tag        = f_reqid;
                res_next.payload_length = cur_len_next;
            end
        end

        if (!failed_reg && !(ends && !fok_eff)) begin
            res_next.buffered_bytes = position_next[LEN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg  <= '0;
            cur_len_reg   <= '0;
            fields_ok_reg <= 1'b0;
            failed_reg    <= 1'b0;
        end else if (s_acc) begin
            position_reg  <= position_next;
            cur_len_reg   <= cur_len_next;
            fields_ok_reg <= fields_ok_next;
            failed_reg    <= failed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc && !failed_reg && in_hdr) begin
            hdr_reg[position_reg[4:0]] <= s_data_byte;
        end
    end

    // result register; refills in the same cycle it drains
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_acc) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            res_reg <= res_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_payload_valid  = res_reg.payload_valid;
    assign m_payload_byte   = res_reg.payload_byte;
    assign m_envelope_done  = res_reg.envelope_done;
    assign m_ver_major      = res_reg.ver_major;
    assign m_ver_minor      = res_reg.ver_minor;
    assign m_domain         = res_reg.domain;
    assign m_operation      = res_reg.operation;
    assign m_kind           = res_reg.kind;
    assign m_req_tag        = res_reg.req_tag;
    assign m_payload_length = res_reg.payload_length;
    assign m_error_code     = res_reg.error_code;
    assign m_buffered_bytes = res_reg.buffered_bytes;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_failed_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        failed_reg |=> failed_reg)
        else $error("failure flag cleared without reset");

    a_done_is_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_envelope_done |-> m_error_code == ERR_OK)
        else $error("envelope done reported with an error");

    a_payload_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        !failed_reg && !in_hdr |->
            (position_reg - POS_W'(HDR_BYTES)) < {1'b0, cur_len_reg})
        else $error("payload position ran past the envelope length");

    a_accept_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_ready)
        else $error("input stalled with an empty result register");

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: message envelope deframer bench
// Feeds byte streams of well-formed envelopes under changing register sets,
// predicts every result record in-bench and compares it field by field, with
// random stalls on both channels, a long receiver hold-off and a sticky
// failure case at the end of the run.
// ----------------------------------------------------------------------------
module tb_top
    import med_pkg::*;
();

    localparam int LONG_HOLD   = 300;   // receiver hold-off, cycles
    localparam int STALL_LIMIT = 2000;  // watchdog: cycles with no transfer
    localparam int TAIL_CYCLES = 8;     // settle time after the last result

    // one full register set
    typedef struct {
        logic [15:0]      exp_major;
        logic [15:0]      max_minor;
        logic [LEN_W-1:0] max_pay;
        logic [15:0]      kind_evt;
        logic [15:0]      kind_req;
        logic [15:0]      kind_rsp;
        logic [15:0]      kind_err;
    } cfg_t;

    // header contents of one envelope
    typedef struct {
        logic [31:0] magic;
        logic [15:0] major;
        logic [15:0] minor;
        logic [15:0] domain;
        logic [15:0] operation;
        logic [15:0] kind;
        logic [15:0] reserved;
        logic [31:0] req_tag;
        logic [31:0] length;
    } env_t;

    // ------------------------------------------------------------------------
    // DUT signals, inputs at known values from time zero
    // ------------------------------------------------------------------------
    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             s_valid     = 1'b0;
    logic             s_ready;
    logic [7:0]       s_data_byte = 8'h00;
    logic             m_valid;
    logic             m_ready     = 1'b0;
    logic             m_payload_valid;
    logic [7:0]       m_payload_byte;
    logic             m_envelope_done;
    logic [15:0]      m_ver_major;
    logic [15:0]      m_ver_minor;
    logic [15:0]      m_domain;
    logic [15:0]      m_operation;
    logic [15:0]      m_kind;
    logic [31:0]      m_req_tag;
    logic [LEN_W-1:0] m_payload_length;
    logic [2:0]       m_error_code;
    logic [LEN_W-1:0] m_buffered_bytes;
    logic             psel        = 1'b0;
    logic             penable     = 1'b0;
    logic             pwrite      = 1'b0;
    logic [4:0]       paddr       = 5'd0;
    logic [31:0]      pwdata      = 32'd0;
    logic [31:0]      prdata;
    logic             pready;

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    // shadow of the DUT registers, starts at the reset values
    cfg_t cfg = '{RST_EXP_MAJOR, RST_MAX_MINOR, RST_MAX_PAY, RST_KIND_EVT,
                  RST_KIND_REQ, RST_KIND_RSP, RST_KIND_ERR};

    // deframer model state
    logic [31:0] pos_cnt     = 32'd0;
    logic [7:0]  hdr_store [HDR_BYTES];
    bit          fields_good = 1'b0;
    bit          is_failed   = 1'b0;
    logic [31:0] cur_len     = 32'd0;

    res_t deframed_results[$];   // records still owed by the DUT
    int   mismatch_count = 0;
    int   bytes_sent     = 0;
    int   stall_cycles   = 0;

    // idle rates in percent, changed per phase
    int   snd_idle_pct = 10;
    int   rcv_idle_pct = 56;

    // long hold-off request: test bumps hold_seq, receiver process counts
    int   hold_seq  = 0;
    int   hold_seen = 0;
    int   hold_left = 0;

    message_envelope_deframer dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_payload_valid  (m_payload_valid),
        .m_payload_byte   (m_payload_byte),
        .m_envelope_done  (m_envelope_done),
        .m_ver_major      (m_ver_major),
        .m_ver_minor      (m_ver_minor),
        .m_domain         (m_domain),
        .m_operation      (m_operation),
        .m_kind           (m_kind),
        .m_req_tag        (m_req_tag),
        .m_payload_length (m_payload_length),
        .m_error_code     (m_error_code),
        .m_buffered_bytes (m_buffered_bytes),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #10 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // deframer model
    // ------------------------------------------------------------------------
    function automatic logic [15:0] hdr16(int at);
        return {hdr_store[5'(at)], hdr_store[5'(at + 1)]};
    endfunction

    function automatic logic [31:0] hdr32(int at);
        return {hdr16(at), hdr16(at + 2)};
    endfunction

    // late header checks; event kind wins when codes collide
    function automatic bit fields_pass();
        logic [15:0] kd;
        logic [31:0] rid;
        bit          known;
        kd    = hdr16(OFS_KIND);
        rid   = hdr32(OFS_REQID);
        known = kd == cfg.kind_evt || kd == cfg.kind_req ||
                kd == cfg.kind_rsp || kd == cfg.kind_err;
        if (hdr16(OFS_MAJOR) != cfg.exp_major || hdr16(OFS_MINOR) > cfg.max_minor ||
            hdr16(OFS_DOMAIN) == 16'd0 || hdr16(OFS_OP) == 16'd0 || !known)
            return 1'b0;
        if (kd == cfg.kind_evt)
            return rid == 32'd0;
        return rid != 32'd0;
    endfunction

    // advance the model by one accepted byte, return the record it causes
    function automatic res_t deframe_byte(logic [7:0] b);
        res_t r;
        bit   ends;
        r    = '0;
        ends = 1'b0;
        if (is_failed) begin
            r.error_code = ERR_FAILED;
            return r;
        end
        if (pos_cnt < HDR_BYTES) begin
            hdr_store[pos_cnt[4:0]] = b;
            pos_cnt++;
            if (pos_cnt == HDR_BYTES) begin
                // early checks on the byte that completes the header
                if (hdr32(OFS_MAGIC) != FRAME_MAGIC || hdr16(OFS_RESERVED) != 16'd0) begin
                    r.error_code = ERR_BAD_MAGIC;
                    is_failed    = 1'b1;
                    pos_cnt      = 32'd0;
                    return r;
                end
                cur_len = hdr32(OFS_LENGTH);
                if (cur_len > {7'd0, cfg.max_pay}) begin
                    r.error_code = ERR_TOO_LONG;
                    is_failed    = 1'b1;
                    pos_cnt      = 32'd0;
                    return r;
                end
                fields_good = fields_pass();
                ends        = cur_len == 32'd0;
            end
        end else begin
            // payload passes straight through, even on a failing last byte
            r.payload_valid = 1'b1;
            r.payload_byte  = b;
            pos_cnt++;
            ends = (pos_cnt - HDR_BYTES) == cur_len;
        end
        if (ends) begin
            pos_cnt = 32'd0;
            if (!fields_good) begin
                r.error_code = ERR_BAD_FIELDS;
                is_failed    = 1'b1;
                return r;
            end
            r.envelope_done  = 1'b1;
            r.ver_major      = hdr16(OFS_MAJOR);
            r.ver_minor      = hdr16(OFS_MINOR);
            r.domain         = hdr16(OFS_DOMAIN);
            r.operation      = hdr16(OFS_OP);
            r.kind           = hdr16(OFS_KIND);
            r.req_tag        = hdr32(OFS_REQID);
            r.payload_length = cur_len[LEN_W-1:0];
        end
        r.buffered_bytes = pos_cnt[LEN_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // receiver: random m_ready, or a long hold-off when requested
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_seen != hold_seq) begin
            hold_seen <= hold_seq;
            hold_left <= LONG_HOLD;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // result checker: every accepted record against the oldest prediction
    // ------------------------------------------------------------------------
    task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (want_v !== got_v) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: %s mismatch, expected %0h got %0h",
                         $realtime, name, want_v, got_v);
        end
    endtask

    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (deframed_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result with no request outstanding", $realtime);
            end else begin
                want = deframed_results.pop_front();
                check_field("payload_valid",  32'(want.payload_valid),
                            32'(m_payload_valid));
                check_field("payload_byte",   32'(want.payload_byte),
                            32'(m_payload_byte));
                check_field("envelope_done",  32'(want.envelope_done),
                            32'(m_envelope_done));
                check_field("ver_major",      32'(want.ver_major),  32'(m_ver_major));
                check_field("ver_minor",      32'(want.ver_minor),  32'(m_ver_minor));
                check_field("domain",         32'(want.domain),     32'(m_domain));
                check_field("operation",      32'(want.operation),  32'(m_operation));
                check_field("kind",           32'(want.kind),       32'(m_kind));
                check_field("req_tag",        want.req_tag,         m_req_tag);
                check_field("payload_length", 32'(want.payload_length),
                            32'(m_payload_length));
                check_field("error_code",     32'(want.error_code), 32'(m_error_code));
                check_field("buffered_bytes", 32'(want.buffered_bytes),
                            32'(m_buffered_bytes));
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without any transfer on either channel
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    // Offer one byte and return at the edge it is taken. s_valid is left high
    // so a following byte goes out back to back; anyone who stops the stream
    // lowers it (wait_drained).
    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = ($urandom_range(99) < snd_idle_pct) ? $urandom_range(4, 1) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        do
            @(posedge aclk);
        while (!s_ready);
        deframed_results.insert(deframed_results.size(), deframe_byte(b));
        bytes_sent++;
    endtask

    // stop the stream and wait until every record has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (deframed_results.size() != 0) @(posedge aclk);
    endtask

    // write the whole register set over APB; only ever called while idle
    task automatic apply_config(cfg_t c);
        logic [31:0] vals [7];
        vals[REG_EXP_MAJOR] = 32'(c.exp_major);
        vals[REG_MAX_MINOR] = 32'(c.max_minor);
        vals[REG_MAX_PAY]   = 32'(c.max_pay);
        vals[REG_KIND_EVT]  = 32'(c.kind_evt);
        vals[REG_KIND_REQ]  = 32'(c.kind_req);
        vals[REG_KIND_RSP]  = 32'(c.kind_rsp);
        vals[REG_KIND_ERR]  = 32'(c.kind_err);
        wait_drained();
        repeat (2) @(posedge aclk);   // let the result register settle, plus margin
        for (int i = 0; i <= int'(REG_KIND_ERR); i++) begin
            // setup phase, then access phase; write lands at the access edge
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= 5'(4 * i);
            pwdata  <= vals[3'(i)];
            @(posedge aclk);
            penable <= 1'b1;
            @(posedge aclk);
        end
        cfg = c;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_nonzero16();
        case ($urandom_range(3))
            0:       return 16'h0001;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(65535, 1));
        endcase
    endfunction

    function automatic cfg_t random_config();
        cfg_t c;
        c.exp_major = pick16();
        c.max_minor = pick16();
        case ($urandom_range(5))
            0:       c.max_pay = '0;
            1:       c.max_pay = 25'd16777216;
            2:       c.max_pay = LEN_W'($urandom_range(30));
            3:       c.max_pay = 25'd65536;
            default: c.max_pay = LEN_W'($urandom_range(1000));
        endcase
        c.kind_evt = pick16();
        c.kind_req = pick16();
        c.kind_rsp = pick16();
        c.kind_err = pick16();
        // colliding kind codes now and then
        case ($urandom_range(5))
            0:       c.kind_req = c.kind_evt;
            1:       c.kind_err = c.kind_rsp;
            default: ;
        endcase
        return c;
    endfunction

    // a header that passes every check under the current registers
    function automatic env_t good_env(int cap);
        env_t e;
        int   lim;
        lim = (cap < int'(cfg.max_pay)) ? cap : int'(cfg.max_pay);
        e.magic     = FRAME_MAGIC;
        e.major     = cfg.exp_major;
        case ($urandom_range(2))
            0:       e.minor = cfg.max_minor;
            1:       e.minor = 16'h0000;
            default: e.minor = 16'($urandom_range(int'(cfg.max_minor)));
        endcase
        e.domain    = pick_nonzero16();
        e.operation = pick_nonzero16();
        e.reserved  = 16'h0000;
        case ($urandom_range(3))
            0:       e.kind = cfg.kind_evt;
            1:       e.kind = cfg.kind_req;
            2:       e.kind = cfg.kind_rsp;
            default: e.kind = cfg.kind_err;
        endcase
        if (e.kind == cfg.kind_evt) begin
            e.req_tag = 32'd0;
        end else begin
            e.req_tag = ($urandom_range(7) == 0) ? 32'hFFFF_FFFF : $urandom;
            if (e.req_tag == 32'd0)
                e.req_tag = 32'd1;
        end
        case ($urandom_range(9))
            0:       e.length = 32'd0;
            1:       e.length = 32'(lim);
            2:       e.length = 32'($urandom_range(lim));
            default: e.length = 32'($urandom_range(lim < 12 ? lim : 12));
        endcase
        return e;
    endfunction

    // header, then pay_bytes random payload bytes; the stream drains before
    // byte pause_at (counted from the first header byte) when it is >= 0
    task automatic send_envelope(env_t e, int pay_bytes, int pause_at);
        logic [HDR_BITS-1:0] hdr;
        hdr = {e.magic, e.major, e.minor, e.domain, e.operation, e.kind,
               e.reserved, e.req_tag, e.length};
        for (int i = 0; i < HDR_BYTES + pay_bytes; i++) begin
            if (i == pause_at)
                wait_drained();
            if (i < HDR_BYTES)
                send_byte(hdr[HDR_BITS-1-8*i -: 8]);
            else
                send_byte(8'($urandom));
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // reset register values: one envelope of every kind, short payloads
    task automatic test_reset_defaults();
        env_t e;
        e = good_env(0);
        e.kind = cfg.kind_evt;   e.req_tag = 32'd0;
        send_envelope(e, 0, -1);
        e = good_env(1);
        e.kind = cfg.kind_req;   e.req_tag = 32'h0000_0001;   e.length = 32'd1;
        send_envelope(e, 1, -1);
        e = good_env(2);
        e.kind = cfg.kind_rsp;   e.req_tag = 32'h8000_0000;   e.length = 32'd2;
        send_envelope(e, 2, -1);
        e = good_env(4);
        e.kind = cfg.kind_err;   e.req_tag = 32'h1234_5678;   e.length = 32'd4;
        send_envelope(e, 4, -1);
    endtask

    // sender stops mid-payload until every record is back, then resumes
    task automatic test_drain_pause();
        env_t e;
        e = good_env(20);
        e.length = 32'd20;
        send_envelope(e, 20, 30);
    endtask

    // long receiver hold-off while the sender keeps offering: the block fills
    // and has to stall its input
    task automatic test_backpressure();
        env_t e;
        e = good_env(60);
        e.length = 32'd60;
        hold_seq++;
        send_envelope(e, 60, -1);
    endtask

    // all-ones fields and a length limit of 16777216
    task automatic test_field_extremes();
        env_t e;
        apply_config(cfg_t'{16'hFFFF, 16'hFFFF, 25'd16777216,
                            16'hFFFF, 16'h0000, 16'h8000, 16'h0001});
        e = good_env(3);
        e.minor = 16'hFFFF;  e.domain = 16'hFFFF;  e.operation = 16'hFFFF;
        e.kind = 16'h0000;   e.req_tag = 32'hFFFF_FFFF;  e.length = 32'd3;
        send_envelope(e, 3, -1);
        e = good_env(0);
        e.kind = 16'hFFFF;   e.req_tag = 32'd0;  e.length = 32'd0;
        send_envelope(e, 0, -1);
        e = good_env(1);
        e.minor = 16'h0000;  e.domain = 16'h0001;  e.operation = 16'h0001;
        e.kind = 16'h8000;   e.req_tag = 32'd1;  e.length = 32'd1;
        send_envelope(e, 1, -1);
    endtask

    // zero length limit and all four kind codes equal: event rule applies
    task automatic test_zero_length_limit();
        env_t e;
        apply_config(cfg_t'{16'h0000, 16'h0000, 25'd0,
                            16'd5, 16'd5, 16'd5, 16'd5});
        repeat (2) begin
            e = good_env(0);
            send_envelope(e, 0, -1);
        end
    endtask

    // payload length exactly at the limit
    task automatic test_length_limit();
        env_t e;
        apply_config(cfg_t'{16'd7, 16'd3, 25'd5, 16'd9, 16'd10, 16'd11, 16'd12});
        e = good_env(5);
        e.kind = 16'd12;  e.req_tag = 32'hA5A5_5A5A;  e.length = 32'd5;
        send_envelope(e, 5, -1);
        e = good_env(5);
        e.kind = 16'd11;  e.req_tag = 32'h0000_0002;  e.length = 32'd5;
        send_envelope(e, 5, -1);
    endtask

    // random well-formed envelopes, fresh register set every dozen
    task automatic test_random_traffic(int snd_pct, int rcv_pct, int byte_budget);
        env_t e;
        int   start;
        int   n;
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        start = bytes_sent;
        n     = 0;
        while (bytes_sent - start < byte_budget) begin
            if (n % 12 == 0)
                apply_config(random_config());
            e = good_env(80);
            send_envelope(e, int'(e.length), -1);
            n++;
        end
    endtask

    // one failing envelope (error is sticky, so only one per run), then noise
    // that must all come back as already-failed
    task automatic test_sticky_failure();
        env_t e;
        int   pay;
        e   = good_env(6);
        pay = 0;
        case ($urandom_range(3))
            0: e.magic    = FRAME_MAGIC ^ (32'd1 << $urandom_range(31));
            1: e.reserved = pick_nonzero16();
            2: e.length   = ($urandom_range(1) == 0) ? {7'd0, cfg.max_pay} + 32'd1
                                                      : 32'hFFFF_FFFF;
            default: begin
                // bad late field; the error lands on the envelope's last byte
                pay = int'(e.length);
                case ($urandom_range(5))
                    0: e.major = cfg.exp_major + 16'd1;
                    1: if (cfg.max_minor != 16'hFFFF)
                           e.minor = cfg.max_minor + 16'd1;
                       else
                           e.domain = 16'h0000;
                    2: e.domain    = 16'h0000;
                    3: e.operation = 16'h0000;
                    4: do
                           e.kind = 16'($urandom);
                       while (e.kind == cfg.kind_evt || e.kind == cfg.kind_req ||
                              e.kind == cfg.kind_rsp || e.kind == cfg.kind_err);
                    default: e.req_tag = (e.kind == cfg.kind_evt) ?
                                         32'hFFFF_FFFF : 32'd0;
                endcase
            end
        endcase
        send_envelope(e, pay, -1);
        repeat (40) send_byte(8'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        snd_idle_pct = 10;
        rcv_idle_pct = 56;
        test_reset_defaults();
        test_drain_pause();
        test_backpressure();
        test_field_extremes();
        test_zero_length_limit();
        test_length_limit();

        test_random_traffic(10, 56, 360);
        test_random_traffic(56, 10, 360);
        test_random_traffic(0, 0, 360);
        test_sticky_failure();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        mismatch_count += deframed_results.size();
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### files.f
rtl/med_pkg.sv
rtl/message_envelope_deframer.sv
bench/tb_top.sv
